// ===== rtl/dht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dht_pkg
// Shared types and constants for the DHT22 frame receiver.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int MAX_INTERVALS = 85;
  localparam int FRAME_BITS    = 40;

  localparam logic [7:0] BIT_THRESHOLD_RST = 8'd16;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd255;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_BIT_THRESHOLD = 1'b0,
    REG_TIMEOUT_TICKS = 1'b1
  } dht_reg_e;

  typedef enum logic [1:0] {
    ST_GOOD  = 2'd0,
    ST_CSUM  = 2'd1,
    ST_SHORT = 2'd2
  } dht_status_e;

  typedef struct packed {
    logic [7:0] bit_threshold;
    logic [7:0] timeout_ticks;
  } dht_cfg_t;

  typedef struct packed {
    logic action;
    logic pin_level;
  } dht_item_t;

  typedef struct packed {
    logic [15:0]        temperature_tenths;
    logic [15:0]        humidity_tenths;
    logic               cache_valid;
    logic               reading_fresh;
    dht_status_e        status;
  } dht_result_t;

endpackage
`default_nettype wire

// ===== rtl/dht_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dht_cfg_regs
// APB register file: bit threshold and timeout length.
// ----------------------------------------------------------------------------
module dht_cfg_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output dht_pkg::dht_cfg_t     cfg_o
);

  dht_pkg::dht_cfg_t cfg_q, cfg_d;
  dht_pkg::dht_reg_e reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = dht_pkg::dht_reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        dht_pkg::REG_BIT_THRESHOLD: cfg_d.bit_threshold = pwdata[7:0];
        dht_pkg::REG_TIMEOUT_TICKS: cfg_d.timeout_ticks = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dht_pkg::REG_BIT_THRESHOLD: prdata = {24'd0, cfg_q.bit_threshold};
      dht_pkg::REG_TIMEOUT_TICKS: prdata = {24'd0, cfg_q.timeout_ticks};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_threshold <= dht_pkg::BIT_THRESHOLD_RST;
      cfg_q.timeout_ticks <= dht_pkg::TIMEOUT_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/dht_frame_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dht_frame_core
// Interval timing, bit capture, frame judgement and reading cache.
// ----------------------------------------------------------------------------
module dht_frame_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  dht_pkg::dht_item_t       item_i,
  input  dht_pkg::dht_cfg_t        cfg_i,
  output logic                     res_valid_o,
  output dht_pkg::dht_result_t     res_o
);

  localparam int FB = dht_pkg::FRAME_BITS;

  logic          capturing_q, capturing_d;
  logic          last_level_q, last_level_d;
  logic [7:0]    ticks_q, ticks_d;
  logic [6:0]    icount_q, icount_d;
  logic [5:0]    bcount_q, bcount_d;
  logic [FB-1:0] frame_q, frame_d;
  logic [15:0]   hum_q, hum_d;
  logic [15:0]   temp_q, temp_d;
  logic          have_q, have_d;

  logic [7:0]    b0, b1, b2, b3, b4, csum;
  logic [14:0]   mag;
  logic          frame_end;
  dht_pkg::dht_status_e status;

  // Byte split of the updated frame
  assign b0   = frame_d[39:32];
  assign b1   = frame_d[31:24];
  assign b2   = frame_d[23:16];
  assign b3   = frame_d[15:8];
  assign b4   = frame_d[7:0];
  assign csum = b0 + b1 + b2 + b3;
  assign mag  = {b2[6:0], b3};

  always_comb begin
    priority if (bcount_d < 6'(FB)) begin
      status = dht_pkg::ST_SHORT;
    end else if (csum != b4) begin
      status = dht_pkg::ST_CSUM;
    end else begin
      status = dht_pkg::ST_GOOD;
    end
  end

  always_comb begin
    capturing_d  = capturing_q;
    last_level_d = last_level_q;
    ticks_d      = ticks_q;
    icount_d     = icount_q;
    bcount_d     = bcount_q;
    frame_d      = frame_q;
    frame_end    = 1'b0;
    if (in_valid_i) begin
      if (item_i.action) begin
        capturing_d  = 1'b1;
        last_level_d = 1'b1;
        ticks_d      = 8'd0;
        icount_d     = 7'd0;
        bcount_d     = 6'd0;
        frame_d      = '0;
      end else if (capturing_q) begin
        if (item_i.pin_level == last_level_q && ticks_q < cfg_i.timeout_ticks) begin
          ticks_d = ticks_q + 8'd1;
        end else begin
          last_level_d = item_i.pin_level;
          ticks_d      = 8'd0;
          // even intervals after the third carry data
          if (icount_q > 7'd2 && !icount_q[0] && bcount_q < 6'(FB)) begin
            frame_d  = {frame_q[FB-2:0], (ticks_q > cfg_i.bit_threshold)};
            bcount_d = bcount_q + 6'd1;
          end
          icount_d = icount_q + 7'd1;
          if (icount_q >= 7'(dht_pkg::MAX_INTERVALS - 1) ||
              ticks_q >= cfg_i.timeout_ticks) begin
            frame_end   = 1'b1;
            capturing_d = 1'b0;
          end
        end
      end
    end
  end

  // Cache update and result build
  always_comb begin
    hum_d  = hum_q;
    temp_d = temp_q;
    have_d = have_q;
    if (frame_end && status == dht_pkg::ST_GOOD) begin
      hum_d  = {b0, b1};
      temp_d = b2[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
      have_d = 1'b1;
    end
  end

  always_comb begin
    res_valid_o              = frame_end;
    res_o.status             = status;
    res_o.reading_fresh      = (status == dht_pkg::ST_GOOD);
    res_o.cache_valid        = have_d;
    res_o.humidity_tenths    = hum_d;
    res_o.temperature_tenths = temp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q  <= 1'b0;
      last_level_q <= 1'b1;
      ticks_q      <= 8'd0;
      icount_q     <= 7'd0;
      bcount_q     <= 6'd0;
      frame_q      <= '0;
      hum_q        <= 16'd0;
      temp_q       <= 16'd0;
      have_q       <= 1'b0;
    end else begin
      capturing_q  <= capturing_d;
      last_level_q <= last_level_d;
      ticks_q      <= ticks_d;
      icount_q     <= icount_d;
      bcount_q     <= bcount_d;
      frame_q      <= frame_d;
      hum_q        <= hum_d;
      temp_q       <= temp_d;
      have_q       <= have_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dht_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dht_out_buf
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module dht_out_buf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  dht_pkg::dht_result_t     push_data_i,
  output logic                     can_push_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dht_pkg::dht_result_t     out_data_o
);

  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  dht_pkg::dht_result_t out_q, out_d;
  dht_pkg::dht_result_t skid_q, skid_d;
  logic                 take;

  assign take       = out_valid_q & out_ready_i;
  assign can_push_o = ~skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d = push_data_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        // output stalled: park the request in the skid entry
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/dht22_frame_receiver_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dht22_frame_receiver_unit
// DHT22 single-wire frame receiver working on sampled pin levels.
// ----------------------------------------------------------------------------
// Output: a result is registered in the result register, or in its skid entry
//   while the output is stalled, when the sample that ends the frame is accepted.
// Throughput: one request per cycle while s_axis_tready is high; state advances
//   at the accepting edge. s_axis_tready drops only when both the result
//   register and its skid entry are full.
// Reset: asynchronous, active low; clears capture state, cache and registers
//   to defaults.
module dht22_frame_receiver_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
  input  wire logic [0:0]  s_axis_tuser,   // [0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] humidity_tenths, [31:16] temperature_tenths
  output logic [3:0]       m_axis_tuser,   // [1:0] status, [2] reading_fresh, [3] cache_valid
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  dht_pkg::dht_cfg_t    cfg;
  dht_pkg::dht_item_t   item;
  dht_pkg::dht_result_t res, out_res;
  logic                 res_valid;
  logic                 in_accept;

  assign item.action    = s_axis_tuser[0];
  assign item.pin_level = s_axis_tdata[0];
  assign in_accept      = s_axis_tvalid & s_axis_tready;

  dht_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dht_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_accept),
    .item_i      (item),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dht_out_buf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .can_push_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {out_res.temperature_tenths, out_res.humidity_tenths};
  assign m_axis_tuser = {out_res.cache_valid, out_res.reading_fresh, out_res.status};

endmodule
`default_nettype wire

// ===== rtl/dht_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dht_checker
// Port-level checks on the receiver's result stream.
// ----------------------------------------------------------------------------
module dht_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [3:0]  m_axis_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[1:0] == dht_pkg::ST_GOOD ||
                       m_axis_tuser[1:0] == dht_pkg::ST_CSUM ||
                       m_axis_tuser[1:0] == dht_pkg::ST_SHORT))
    else $error("bad status code");

  // good frame always fresh and cached, and fresh only on a good frame
  a_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[2] == (m_axis_tuser[1:0] == dht_pkg::ST_GOOD)) &&
                      (!m_axis_tuser[2] || m_axis_tuser[3]))
    else $error("fresh flag inconsistent with status");

  a_nocache: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tdata == 32'd0)
    else $error("values present without a cached reading");

  // once a reading is cached it stays valid on later results
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser[3] |=>
      !m_axis_tvalid || m_axis_tuser[3])
    else $error("cache valid flag dropped");

endmodule

bind dht22_frame_receiver_unit dht_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== test/dht22_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dht22_frame_checker
// Watches the sample, result and register ports of the DHT22 frame receiver.
// It tracks the capture in its own copy of the state, queues the reading each
// finished frame should produce, and compares every result taken by the sink.
// ----------------------------------------------------------------------------
module dht22_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // [0] pin_level, [7:1] zero
  input  logic [0:0]  s_tuser_i,   // [0] action
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,   // [15:0] humidity_tenths, [31:16] temperature_tenths
  input  logic [3:0]  m_tuser_i,   // [1:0] status, [2] reading_fresh, [3] cache_valid
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o
);

  dht_pkg::dht_cfg_t    cfg;
  logic                 capturing;
  logic                 last_level;
  logic [7:0]           ticks;
  logic [6:0]           n_intervals;
  logic [5:0]           n_bits;
  logic [39:0]          bits;
  logic [15:0]          hum_cache;
  logic [15:0]          temp_cache;
  logic                 cache_ok;
  dht_pkg::dht_result_t readings_q[$];
  int                   fails;

  task automatic close_frame();
    logic [7:0]  b0, b1, b2, b3, b4;
    logic [15:0] mag;
    dht_pkg::dht_result_t r;
    {b0, b1, b2, b3, b4} = bits;
    if (n_bits < dht_pkg::FRAME_BITS) r.status = dht_pkg::ST_SHORT;
    else if (8'(b0 + b1 + b2 + b3) != b4) r.status = dht_pkg::ST_CSUM;
    else r.status = dht_pkg::ST_GOOD;
    r.reading_fresh = (r.status == dht_pkg::ST_GOOD);
    if (r.status == dht_pkg::ST_GOOD) begin
      // bit 15 carries the sign, the rest is the magnitude
      mag        = {1'b0, b2[6:0], b3};
      hum_cache  = {b0, b1};
      temp_cache = b2[7] ? 16'd0 - mag : mag;
      cache_ok   = 1'b1;
    end
    r.cache_valid        = cache_ok;
    r.humidity_tenths    = hum_cache;
    r.temperature_tenths = temp_cache;
    capturing = 1'b0;
    readings_q.push_back(r);
  endtask

  task automatic take_sample(input logic lvl);
    int len;
    int idx;
    if (!capturing) return;
    if (lvl == last_level && ticks < cfg.timeout_ticks) begin
      ticks = ticks + 8'd1;
      return;
    end
    // this sample closes the running interval
    len        = ticks;
    idx        = n_intervals;
    last_level = lvl;
    ticks      = '0;
    if (idx > 2 && idx % 2 == 0 && n_bits < dht_pkg::FRAME_BITS) begin
      bits   = {bits[38:0], len > cfg.bit_threshold};
      n_bits = n_bits + 6'd1;
    end
    n_intervals = 7'(idx + 1);
    if (idx + 1 >= dht_pkg::MAX_INTERVALS || len >= cfg.timeout_ticks) close_frame();
  endtask

  task automatic check_reading();
    dht_pkg::dht_result_t want;
    dht_pkg::dht_result_t got;
    got.status             = dht_pkg::dht_status_e'(m_tuser_i[1:0]);
    got.reading_fresh      = m_tuser_i[2];
    got.cache_valid        = m_tuser_i[3];
    got.humidity_tenths    = m_tdata_i[15:0];
    got.temperature_tenths = m_tdata_i[31:16];
    if (readings_q.size() == 0) begin
      if (fails < 10) $display("%0t: unexpected result status=%0d", $time, got.status);
      fails++;
      return;
    end
    want = readings_q.pop_front();
    if (want.status != got.status || want.reading_fresh != got.reading_fresh ||
        want.cache_valid != got.cache_valid ||
        want.humidity_tenths != got.humidity_tenths ||
        want.temperature_tenths != got.temperature_tenths) begin
      if (fails < 10)
        $display("%0t: mismatch exp/act status %0d/%0d fresh %0b/%0b valid %0b/%0b",
                 $time, want.status, got.status, want.reading_fresh, got.reading_fresh,
                 want.cache_valid, got.cache_valid,
                 " hum %0d/%0d temp %0d/%0d",
                 want.humidity_tenths, got.humidity_tenths,
                 $signed(want.temperature_tenths), $signed(got.temperature_tenths));
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.bit_threshold = dht_pkg::BIT_THRESHOLD_RST;
      cfg.timeout_ticks = dht_pkg::TIMEOUT_TICKS_RST;
      capturing   = 1'b0;
      last_level  = 1'b1;
      ticks       = '0;
      n_intervals = '0;
      n_bits      = '0;
      bits        = '0;
      hum_cache   = '0;
      temp_cache  = '0;
      cache_ok    = 1'b0;
      fails       = 0;
      readings_q.delete();
    end else begin
      // results are registered before they leave, so check before predicting
      if (m_tvalid_i && m_tready_i) check_reading();
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i[0]) begin
          capturing   = 1'b1;
          last_level  = 1'b1;
          ticks       = '0;
          n_intervals = '0;
          n_bits      = '0;
          bits        = '0;
        end else begin
          take_sample(s_tdata_i[0]);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (dht_pkg::dht_reg_e'(paddr_i[2]))
          dht_pkg::REG_BIT_THRESHOLD: cfg.bit_threshold = pwdata_i[7:0];
          dht_pkg::REG_TIMEOUT_TICKS: cfg.timeout_ticks = pwdata_i[7:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= readings_q.size();
  end

endmodule

// ===== test/tb_dht22_frame_receiver_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dht22_frame_receiver_unit
// Drives sampled pin levels and arm requests into the frame receiver: a few
// hand-built frames first, then random frames, cut-off frames and noise under
// several threshold and timeout settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_dht22_frame_receiver_unit;

  localparam int IDLE_LIMIT    = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 70;
  localparam int PHASE_RESULTS = 2;
  localparam int N_PHASES      = 5;
  localparam int PRESSURE_PH   = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] pin_level, [7:1] zero
  logic [0:0]  s_axis_tuser;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [15:0] humidity_tenths, [31:16] temperature_tenths
  logic [3:0]  m_axis_tuser;   // [1:0] status, [2] reading_fresh, [3] cache_valid
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fails;
  int pending;
  int items_sent   = 0;
  int results_seen = 0;
  int idle_cycles  = 0;
  int thr_now      = dht_pkg::BIT_THRESHOLD_RST;
  int to_now       = dht_pkg::TIMEOUT_TICKS_RST;
  bit src_gaps_on  = 1'b1;
  bit sink_gaps_on = 1'b1;
  bit hold_req     = 1'b0;
  bit src_busy     = 1'b0;

  // threshold / timeout per random phase, extremes included
  int phase_thr[N_PHASES] = '{2, 0, 0, 255, 3};
  int phase_to[N_PHASES]  = '{8, 4, 1, 255, 0};

  dht22_frame_receiver_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  dht22_frame_checker u_frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result sink: random stalls, plus one long hold on request
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && sink_gaps_on) begin
        r = $urandom_range(0, 99);
        if (r < 15) stall_left = $urandom_range(1, 3);
        else if (r < 17) stall_left = $urandom_range(10, 40);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input bit arm, input bit lvl);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= arm;
    s_axis_tdata  <= {7'd0, lvl};
    src_busy = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      src_busy = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_run(input bit lvl, input int n);
    repeat (n) send_item(1'b0, lvl);
  endtask

  task automatic wait_quiet();
    if (src_busy) begin
      s_axis_tvalid <= 1'b0;
      src_busy = 1'b0;
    end
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input dht_pkg::dht_reg_e idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_timing(input int thr, input int to);
    wait_quiet();
    apb_write(dht_pkg::REG_BIT_THRESHOLD, 8'(thr));
    apb_write(dht_pkg::REG_TIMEOUT_TICKS, 8'(to));
    thr_now = thr;
    to_now  = to;
  endtask

  // high-interval length for a data bit, hugging the threshold where cheap
  function automatic int bit_len(input bit one);
    int hi;
    if (one && thr_now + 1 <= to_now - 1) begin
      hi = (thr_now + 4 < to_now - 1) ? thr_now + 4 : to_now - 1;
      return $urandom_range(thr_now + 1, hi);
    end
    hi = (thr_now < to_now - 1) ? thr_now : to_now - 1;
    if (hi <= 24 && $urandom_range(0, 1)) return hi;
    return $urandom_range(0, (hi < 6) ? hi : 6);
  endfunction

  function automatic int filler_len();
    return $urandom_range(0, (to_now - 1 < 6) ? to_now - 1 : 6);
  endfunction

  function automatic bit level_of(input int i);
    return (i % 2 == 0);
  endfunction

  // cut_at < MAX_INTERVALS: interval cut_at is held until it times out
  task automatic send_frame(input logic [39:0] data, input int cut_at, input bit spare);
    int  len;
    int  bit_idx;
    bit  one;
    send_item(1'b1, $urandom_range(0, 1));
    bit_idx = 0;
    for (int i = 0; i < dht_pkg::MAX_INTERVALS && i <= cut_at; i++) begin
      if (i > 0) send_item(1'b0, level_of(i));
      if (i == cut_at) begin
        send_run(level_of(i), to_now);
        send_item(1'b0, $urandom_range(0, 1));
      end else begin
        if (i > 2 && i % 2 == 0) begin
          one = (bit_idx < dht_pkg::FRAME_BITS) ?
                data[dht_pkg::FRAME_BITS - 1 - bit_idx] : spare;
          bit_idx++;
          len = bit_len(one);
        end else begin
          len = filler_len();
        end
        send_run(level_of(i), len);
      end
    end
    if (cut_at >= dht_pkg::MAX_INTERVALS) send_item(1'b0, level_of(dht_pkg::MAX_INTERVALS));
  endtask

  function automatic logic [39:0] make_reading(input bit good);
    logic [7:0] b0, b1, b2, b3, cs;
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    b2 = 8'($urandom);
    b3 = 8'($urandom);
    if ($urandom_range(0, 15) == 0) begin
      b2 = 8'h80;
      b3 = 8'h00;
    end
    cs = b0 + b1 + b2 + b3;
    if (!good) cs = cs ^ 8'($urandom_range(1, 255));
    return {b0, b1, b2, b3, cs};
  endfunction

  task automatic send_noise();
    repeat ($urandom_range(5, 30))
      send_item($urandom_range(0, 9) == 0, $urandom_range(0, 1));
  endtask

  task automatic random_sequence();
    int r;
    r = $urandom_range(0, 99);
    if (to_now == 0 || r >= 80) send_noise();
    else if (r < 55) send_frame(make_reading($urandom_range(0, 9) < 7),
                                dht_pkg::MAX_INTERVALS, $urandom_range(0, 1));
    else send_frame(make_reading(1'b1), $urandom_range(0, dht_pkg::MAX_INTERVALS - 1),
                    1'b0);
  endtask

  initial begin
    int items0;
    int results0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing
    send_item(1'b0, 1'b0);                          // samples before any arm
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b0);                          // capture then re-arm mid-frame
    send_run(1'b1, 3);
    send_item(1'b0, 1'b0);
    send_run(1'b0, 2);
    send_frame(40'hFFFFFFFFFC, 4, 1'b0);            // timed-out interval is a data bit

    // hand-built frames at short timing
    set_timing(0, 3);
    send_frame(40'h028C806573, 10, 1'b0);           // short, nothing cached yet
    send_frame(40'h01F400E1D7, dht_pkg::MAX_INTERVALS, 1'b1); // bad sum, nothing cached
    send_frame(40'h028C806573, dht_pkg::MAX_INTERVALS, 1'b1); // negative temperature
    send_frame(40'h0000800080, dht_pkg::MAX_INTERVALS, 1'b0); // sign set, zero magnitude
    send_frame(40'h01F400E1D7, dht_pkg::MAX_INTERVALS, 1'b0); // bad sum, cache returned

    for (int p = 0; p < N_PHASES; p++) begin
      set_timing(phase_thr[p], phase_to[p]);
      src_gaps_on  = (p % 3 != 1);
      sink_gaps_on = (p % 3 != 2);
      items0   = items_sent;
      results0 = results_seen;
      if (p == PRESSURE_PH) begin
        // sink holds off while quick frames keep coming, so the input backs up
        src_gaps_on = 1'b0;
        hold_req    = 1'b1;
        repeat (30) begin
          send_item(1'b1, $urandom_range(0, 1));
          send_run(1'b1, 2);
        end
        src_gaps_on = 1'b1;
      end
      while ((items_sent - items0 < PHASE_ITEMS || results_seen - results0 < PHASE_RESULTS)
             && items_sent - items0 < 20 * PHASE_ITEMS)
        random_sequence();
    end

    wait_quiet();
    repeat (16) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dht_pkg.sv
rtl/dht_cfg_regs.sv
rtl/dht_frame_core.sv
rtl/dht_out_buf.sv
rtl/dht22_frame_receiver_unit.sv
rtl/dht_checker.sv
test/dht22_frame_checker.sv
test/tb_dht22_frame_receiver_unit.sv
